// ===== rtl/krev_pkg.sv =====
// Shared constants and types of the k-group stream reverser.
package krev_pkg;

	localparam int MAX_GROUP_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int VAL_W         = 32;

	// controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // accept the input beat into the group buffer
		logic issue;  // read the next buffered value towards the output
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic emit;       // the beat on the input closes a group
		logic last_rd;    // the pending read is the last of the group
		logic slot_free;  // the read stage can take a new value
	} sts_t;

endpackage

// ===== rtl/krev_in_if.sv =====
// Input channel: one value per beat with an end-of-sequence flag.
interface krev_in_if;
	logic                    valid;
	logic                    ready;
	logic signed [31:0]      value;
	logic                    final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink   (input valid, input value, input final_item, output ready);
endinterface

// ===== rtl/krev_out_if.sv =====
// Output channel: one reordered value per beat with a last flag.
interface krev_out_if;
	logic                    valid;
	logic                    ready;
	logic signed [31:0]      out_value;
	logic                    out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// ===== rtl/krev_cfg_if.sv =====
// Configuration write channel carrying the group size.
interface krev_cfg_if;
	logic        valid;
	logic        ready;
	logic [4:0]  group_size;

	modport source (output valid, output group_size, input ready);
	modport sink   (input valid, input group_size, output ready);
endinterface

// ===== rtl/k_group_stream_reverser_core.sv =====
// Top level of the k-group stream reverser.
//
//  channel  role    beat contents
//  -------  ------  ---------------------------------------
//  in_ch    sink    value (signed 32), final_item
//  out_ch   source  out_value (signed 32), out_last
//  cfg      sink    group_size (5 bits), always ready
//
// Input beats are accepted while the controller is idle; when a beat closes
// a group of n values the input stalls while the buffer's single read port
// drains them, one per cycle unless the output stalls. Each read passes the
// read stage and then the output register; output stalls freeze the read
// stage and then the drain. Reset clears the fill count and sets the group
// size to one; buffer contents are not cleared.
module k_group_stream_reverser_core #(
	parameter int MAX_GROUP = krev_pkg::MAX_GROUP_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	krev_in_if.sink       in_ch,
	krev_out_if.source    out_ch,
	krev_cfg_if.sink      cfg
);
	import krev_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	krev_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	krev_dp #(
		.MAX_GROUP (MAX_GROUP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (in_ch.value),
		.in_final  (in_ch.final_item),
		.cfg_valid (cfg.valid),
		.cfg_size  (cfg.group_size),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_value (out_ch.out_value),
		.out_last  (out_ch.out_last)
	);

endmodule

// ===== rtl/krev_ctrl.sv =====
// Controller: accepts beats while idle and sequences the drain of a group.
module krev_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  krev_pkg::sts_t sts,
	output krev_pkg::cmd_t cmd
);
	import krev_pkg::*;

	state_t state_q;
	state_t state_d;

	// decode commands from the state
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && sts.emit) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.issue = sts.slot_free;
				if (sts.slot_free && sts.last_rd) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loading and draining never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.issue))
		else $error("load and read issued together");

	// a closing beat always starts a drain
	a_emit_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && sts.emit) |=> (state_q == ST_DRAIN))
		else $error("group closed without drain");

	// drain only ends on the last read
	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !(cmd.issue && sts.last_rd)) |=> (state_q == ST_DRAIN))
		else $error("drain left early");

endmodule

// ===== rtl/krev_dp.sv =====
// Datapath: group buffer, fill count, read stage and output register.
module krev_dp #(
	parameter int MAX_GROUP = krev_pkg::MAX_GROUP_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  krev_pkg::cmd_t                     cmd,
	output krev_pkg::sts_t                     sts,
	input  logic signed [krev_pkg::VAL_W-1:0]  in_value,
	input  logic                               in_final,
	input  logic                               cfg_valid,
	input  logic [krev_pkg::CFG_W-1:0]         cfg_size,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [krev_pkg::VAL_W-1:0]  out_value,
	output logic                               out_last
);
	import krev_pkg::*;

	localparam int IDX_W = $clog2(MAX_GROUP);
	localparam int CNT_W = IDX_W + 1;

	logic [VAL_W-1:0]  mem [MAX_GROUP];

	logic [CFG_W-1:0]  size_q;
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  rem_q;
	logic              rev_q;
	logic              fin_q;

	logic [VAL_W-1:0]  data_s1;
	logic              last_s1;
	logic              valid_s1;

	logic [VAL_W-1:0]  out_value_q;
	logic              out_last_q;
	logic              out_valid_q;

	logic [CNT_W-1:0]  k_eff;
	logic [CNT_W-1:0]  n;
	logic              full;
	logic              adv;

	// clamp the group size to one..MAX_GROUP
	always_comb begin
		if (size_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (int'(size_q) > MAX_GROUP) begin
			k_eff = CNT_W'(MAX_GROUP);
		end else begin
			k_eff = CNT_W'(size_q);
		end
	end

	assign n    = {1'b0, fill_q} + CNT_W'(1);
	assign full = (n >= k_eff);
	assign adv  = valid_s1 && (!out_valid_q || out_ready);

	assign sts.emit      = full || in_final;
	assign sts.last_rd   = (rem_q == '0);
	assign sts.slot_free = !valid_s1 || adv;

	// hold the group size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			size_q <= cfg_size;
		end
	end

	// write the buffer at the fill position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[fill_q] <= in_value;
		end
	end

	// registered buffer read
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			data_s1 <= mem[ptr_q];
			last_s1 <= fin_q && (rem_q == '0);
		end
	end

	// fill count and drain pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
			rem_q  <= '0;
			rev_q  <= 1'b0;
			fin_q  <= 1'b0;
		end else if (cmd.load) begin
			if (full || in_final) begin
				fill_q <= '0;
				rev_q  <= full;
				fin_q  <= in_final;
				rem_q  <= fill_q;
				ptr_q  <= full ? fill_q : '0;
			end else begin
				fill_q <= n[IDX_W-1:0];
			end
		end else if (cmd.issue) begin
			rem_q <= rem_q - IDX_W'(1);
			ptr_q <= rev_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= data_s1;
			out_last_q  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = $signed(out_value_q);
	assign out_last  = out_last_q;

	// reads stay inside the buffer
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (int'(ptr_q) < MAX_GROUP))
		else $error("buffer read out of range");

	// a closed group clears the fill count
	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && sts.emit) |=> (fill_q == '0))
		else $error("fill count not cleared");

	// an issued read lands in the read stage
	a_issue_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> valid_s1)
		else $error("issued read lost");

endmodule
